[design/slsmp_pkg.sv]
`timescale 1ns / 1ps
package slsmp_pkg;

  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned FRACTION_BITS  = 16;
  localparam int unsigned STORE_DEPTH    = 262144;
  localparam int unsigned INDEX_BITS     = $clog2(STORE_DEPTH);
  localparam int unsigned POS_BITS       = 24;
  localparam int unsigned FRAMES_BITS    = 19;
  localparam int unsigned STEP_BITS      = FRACTION_BITS + 3;
  localparam int unsigned CHANCE_BITS    = 17;
  localparam int unsigned TRACK_BITS     = 25;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 25;
  localparam int unsigned LFSR_BITS      = 32;
  localparam int unsigned DRAW_BITS      = 16;

  localparam logic [LFSR_BITS-1:0] LFSR_MASK = 32'h8020_0003;

  // register indexes of the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_DJFX    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REVERSE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCATTER = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANCE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK   = 3'd4;

  typedef enum logic [1:0] {
    CMD_FRAME  = 2'd0,
    CMD_START  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  function automatic logic [LFSR_BITS-1:0] lfsr_advance(input logic [LFSR_BITS-1:0] s);
    return (s >> 1) ^ (s[0] ? LFSR_MASK : '0);
  endfunction

endpackage

[design/slsmp_if.sv]
`timescale 1ns / 1ps
interface slsmp_in_if import slsmp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  cmd_t                   command;
  sample_t                in_left;
  sample_t                in_right;
  logic [POS_BITS-1:0]    start_position;
  logic [FRAMES_BITS-1:0] loop_frames;

  modport source(output valid, command, in_left, in_right, start_position, loop_frames,
                 input ready);
  modport sink(input valid, command, in_left, in_right, start_position, loop_frames,
               output ready);
endinterface

interface slsmp_out_if import slsmp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  sample_t               out_left;
  sample_t               out_right;
  logic [POS_BITS-1:0]   resume_position;
  logic                  status;
  logic                  looping;
  logic [INDEX_BITS-1:0] loop_index;

  modport source(output valid, out_left, out_right, resume_position, status, looping,
                 loop_index, input ready);
  modport sink(input valid, out_left, out_right, resume_position, status, looping,
               loop_index, output ready);
endinterface

[design/slsmp_ram.sv]
`timescale 1ns / 1ps
module slsmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/slip_loop_sampler_core.sv]
`timescale 1ns / 1ps
// Pass-through frame, start, stop: accept in IDLE, then S_DONE loads the out beat register.
// Loop frame: S_DRAW for a scatter draw and S_JUMP on a jump, then S_MIRROR, S_RDA, S_RDB,
// S_RDC, S_MULL, S_ADDL, S_MULR, S_ADDR when interpolating, S_ADV0, one S_ADV step per whole
// step crossed (0..4) and S_DONE; one ring read port, one shared interpolation multiplier.
// Length update: new pitch step from the bit-serial divider (one quotient bit a cycle).
// Throughput: one item at a time; in ready only in IDLE; an out beat may wait in its register.
// Reset (sync, rst_n low): control, loop state and config to defaults; ring contents kept.
module slip_loop_sampler_core import slsmp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  slsmp_in_if.sink                  in_ch,
  slsmp_out_if.source               out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [STEP_BITS-1:0]   ONE_STEP   = STEP_BITS'(1) << FRACTION_BITS;
  localparam logic [STEP_BITS-1:0]   QUARTER    = ONE_STEP >> 2;
  localparam logic [STEP_BITS-1:0]   FOUR_STEP  = ONE_STEP << 2;
  localparam logic [FRAMES_BITS-1:0] MAX_FRAMES = FRAMES_BITS'(STORE_DEPTH);
  localparam int unsigned DIV_BITS  = FRAMES_BITS + FRACTION_BITS;
  localparam int unsigned PROD_BITS = SAMPLE_BITS + FRACTION_BITS + 2;
  localparam int unsigned CNT_BITS  = $clog2(DIV_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DRAW, S_JUMP, S_MIRROR, S_RDA, S_RDB, S_RDC,
    S_MULL, S_ADDL, S_MULR, S_ADDR, S_ADV0, S_ADV, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  // config
  logic                   djfx_r, reverse_r, scatter_r;
  logic [CHANCE_BITS-1:0] chance_r;
  logic [TRACK_BITS-1:0]  track_r;

  // loop state
  logic [INDEX_BITS-1:0]    write_index_r;
  logic [POS_BITS-1:0]      origin_r;
  logic [FRAMES_BITS-1:0]   loop_length_r;
  logic [FRAMES_BITS-1:0]   base_length_r;
  logic [INDEX_BITS-1:0]    read_index_r;
  logic [FRACTION_BITS-1:0] frac_r;
  logic [STEP_BITS-1:0]     pitch_r;
  logic [POS_BITS-1:0]      bg_r;
  logic                     active_r;
  logic [LFSR_BITS-1:0]     lfsr_r;

  // datapath
  logic [INDEX_BITS-1:0]       i0_r;
  logic [FRACTION_BITS-1:0]    af_r;
  logic [2*SAMPLE_BITS-1:0]    a_r, b_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic [2:0]                  adv_cnt_r;
  logic [DIV_BITS-1:0]         div_q_r;
  logic [FRAMES_BITS-1:0]      div_rem_r;
  logic [CNT_BITS-1:0]         div_cnt_r;

  // pending result and out register
  sample_t             res_left_r, res_right_r;
  logic [POS_BITS-1:0] res_resume_r;
  logic                res_status_r;
  logic                out_valid_r;
  sample_t             out_left_r, out_right_r;
  logic [POS_BITS-1:0] out_resume_r;
  logic                out_status_r, out_looping_r;
  logic [INDEX_BITS-1:0] out_index_r;

  logic in_fire;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_left        = out_left_r;
  assign out_ch.out_right       = out_right_r;
  assign out_ch.resume_position = out_resume_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.looping         = out_looping_r;
  assign out_ch.loop_index      = out_index_r;

  // ring store: {left, right}
  logic                     ram_we;
  logic [INDEX_BITS-1:0]    ram_raddr;
  logic [2*SAMPLE_BITS-1:0] ram_rdata;

  assign ram_we    = in_fire && (in_ch.command == CMD_FRAME) && !active_r;
  assign ram_raddr = (state_r == S_RDB) ? i0_r + INDEX_BITS'(1) : i0_r;

  slsmp_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index_r),
    .wdata ({in_ch.in_left, in_ch.in_right}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scatter draw
  logic [LFSR_BITS-1:0]           lfsr_nxt;
  logic [DRAW_BITS-1:0]           draw;
  logic [DRAW_BITS+FRAMES_BITS-1:0] jump_prod;
  assign lfsr_nxt  = lfsr_advance(lfsr_r);
  assign draw      = lfsr_nxt[LFSR_BITS-1 -: DRAW_BITS];
  assign jump_prod = draw * loop_length_r;

  // reverse mirror of the read position
  logic [FRAMES_BITS-1:0]   mirror_w;
  logic [INDEX_BITS-1:0]    mirror;
  logic [INDEX_BITS-1:0]    ai;
  logic [FRACTION_BITS-1:0] af;
  assign mirror_w = loop_length_r - FRAMES_BITS'(1) - FRAMES_BITS'(read_index_r);
  assign mirror   = mirror_w[INDEX_BITS-1:0];

  always_comb begin
    ai = read_index_r;
    af = frac_r;
    if (reverse_r) begin
      priority if (frac_r == '0) begin
        ai = mirror;
        af = '0;
      end else if (mirror == '0) begin
        ai = '0;
        af = '0;
      end else begin
        ai = mirror - INDEX_BITS'(1);
        af = -frac_r;   // one minus fraction
      end
    end
  end

  // shared multiplier for interpolation: (b - a) * frac
  logic signed [SAMPLE_BITS:0]  dl, dr, dsel;
  logic signed [PROD_BITS-1:0]  mult_p;
  logic                         interp;
  assign dl     = $signed({b_r[2*SAMPLE_BITS-1], b_r[2*SAMPLE_BITS-1 -: SAMPLE_BITS]})
                - $signed({a_r[2*SAMPLE_BITS-1], a_r[2*SAMPLE_BITS-1 -: SAMPLE_BITS]});
  assign dr     = $signed({b_r[SAMPLE_BITS-1], b_r[SAMPLE_BITS-1:0]})
                - $signed({a_r[SAMPLE_BITS-1], a_r[SAMPLE_BITS-1:0]});
  assign dsel   = (state_r == S_MULR) ? dr : dl;
  assign mult_p = dsel * $signed({1'b0, af_r});
  assign interp = djfx_r && (pitch_r != ONE_STEP);

  // a + prod / one, truncated toward zero
  function automatic sample_t blend(input sample_t a, input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] s;
    logic signed [PROD_BITS-1:0] q;
    s = $signed({{2{a[SAMPLE_BITS-1]}}, a, {FRACTION_BITS{1'b0}}}) + p;
    q = s >>> FRACTION_BITS;
    if (s[PROD_BITS-1] && (s[FRACTION_BITS-1:0] != '0)) begin
      q = q + PROD_BITS'(1);
    end
    return q[SAMPLE_BITS-1:0];
  endfunction

  // position advance
  logic [STEP_BITS-1:0]         step_use;
  logic [STEP_BITS:0]           fsum;
  logic signed [STEP_BITS+1:0]  fdiff;
  logic signed [STEP_BITS+1:0]  fshift;
  logic [TRACK_BITS-1:0]        bg_inc;
  assign step_use = djfx_r ? pitch_r : ONE_STEP;
  assign fsum     = (STEP_BITS+1)'(frac_r) + (STEP_BITS+1)'(step_use);
  assign fdiff    = $signed((STEP_BITS+2)'(frac_r)) - $signed((STEP_BITS+2)'(step_use));
  assign fshift   = fdiff >>> FRACTION_BITS;
  assign bg_inc   = TRACK_BITS'(bg_r) + TRACK_BITS'(1);

  // divider step
  logic [FRAMES_BITS:0]   div_trial;
  logic                   div_bit;
  assign div_trial = {div_rem_r, div_q_r[DIV_BITS-1]};
  assign div_bit   = (div_trial >= (FRAMES_BITS+1)'(loop_length_r));

  logic bad_frames;
  assign bad_frames = (in_ch.loop_frames == '0) || (in_ch.loop_frames > MAX_FRAMES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      djfx_r        <= 1'b0;
      reverse_r     <= 1'b0;
      scatter_r     <= 1'b0;
      chance_r      <= CHANCE_BITS'(6554);
      track_r       <= TRACK_BITS'(1) << POS_BITS;
      write_index_r <= '0;
      origin_r      <= '0;
      loop_length_r <= '0;
      base_length_r <= '0;
      read_index_r  <= '0;
      frac_r        <= '0;
      pitch_r       <= ONE_STEP;
      bg_r          <= '0;
      active_r      <= 1'b0;
      lfsr_r        <= LFSR_BITS'(1);
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DJFX:    djfx_r    <= cfg_data[0];
          REG_REVERSE: reverse_r <= cfg_data[0];
          REG_SCATTER: scatter_r <= cfg_data[0];
          REG_CHANCE:  chance_r  <= cfg_data[CHANCE_BITS-1:0];
          REG_TRACK:   track_r   <= cfg_data[TRACK_BITS-1:0];
          default: ;
        endcase
      end

      // S_DONE refills the out register itself
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_ch.command)
              CMD_FRAME: begin
                res_resume_r <= '0;
                res_status_r <= 1'b0;
                if (active_r) begin
                  res_left_r  <= '0;
                  res_right_r <= '0;
                  state_r     <= scatter_r ? S_DRAW : S_MIRROR;
                end else begin
                  res_left_r    <= in_ch.in_left;
                  res_right_r   <= in_ch.in_right;
                  write_index_r <= write_index_r + INDEX_BITS'(1);
                  state_r       <= S_DONE;
                end
              end
              CMD_START: begin
                res_left_r   <= '0;
                res_right_r  <= '0;
                res_resume_r <= '0;
                res_status_r <= bad_frames;
                state_r      <= S_DONE;
                if (!bad_frames) begin
                  loop_length_r <= in_ch.loop_frames;
                  base_length_r <= in_ch.loop_frames;
                  origin_r      <= in_ch.start_position;
                  read_index_r  <= '0;
                  frac_r        <= '0;
                  pitch_r       <= ONE_STEP;
                  bg_r          <= in_ch.start_position;
                  active_r      <= 1'b1;
                end
              end
              CMD_UPDATE: begin
                res_left_r   <= '0;
                res_right_r  <= '0;
                res_resume_r <= '0;
                if (!active_r || bad_frames) begin
                  res_status_r <= 1'b1;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r  <= 1'b0;
                  loop_length_r <= in_ch.loop_frames;
                  if (FRAMES_BITS'(read_index_r) >= in_ch.loop_frames) begin
                    read_index_r <= INDEX_BITS'(in_ch.loop_frames - FRAMES_BITS'(1));
                  end
                  div_q_r   <= {base_length_r, {FRACTION_BITS{1'b0}}};
                  div_rem_r <= '0;
                  div_cnt_r <= CNT_BITS'(DIV_BITS);
                  state_r   <= S_DIV;
                end
              end
              CMD_STOP: begin
                res_left_r  <= '0;
                res_right_r <= '0;
                state_r     <= S_DONE;
                if (!active_r) begin
                  res_status_r <= 1'b1;
                  res_resume_r <= '0;
                end else begin
                  res_status_r <= 1'b0;
                  res_resume_r <= bg_r;
                  active_r     <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_DRAW: begin
          lfsr_r  <= lfsr_nxt;
          state_r <= (CHANCE_BITS'(draw) < chance_r) ? S_JUMP : S_MIRROR;
        end
        S_JUMP: begin
          lfsr_r       <= lfsr_nxt;
          read_index_r <= jump_prod[DRAW_BITS +: INDEX_BITS];
          frac_r       <= '0;
          state_r      <= S_MIRROR;
        end
        S_MIRROR: begin
          i0_r    <= origin_r[INDEX_BITS-1:0] + ai;
          af_r    <= af;
          state_r <= S_RDA;
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          a_r     <= ram_rdata;
          state_r <= S_RDC;
        end
        S_RDC: begin
          b_r <= ram_rdata;
          if (interp) begin
            state_r <= S_MULL;
          end else begin
            res_left_r  <= a_r[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
            res_right_r <= a_r[SAMPLE_BITS-1:0];
            state_r     <= S_ADV0;
          end
        end
        S_MULL: begin
          prod_r  <= mult_p;
          state_r <= S_ADDL;
        end
        S_ADDL: begin
          res_left_r <= blend(a_r[2*SAMPLE_BITS-1 -: SAMPLE_BITS], prod_r);
          state_r    <= S_MULR;
        end
        S_MULR: begin
          prod_r  <= mult_p;
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          res_right_r <= blend(a_r[SAMPLE_BITS-1:0], prod_r);
          state_r     <= S_ADV0;
        end
        S_ADV0: begin
          if (reverse_r) begin
            frac_r    <= fdiff[FRACTION_BITS-1:0];
            adv_cnt_r <= 3'(-fshift);
          end else begin
            frac_r    <= fsum[FRACTION_BITS-1:0];
            adv_cnt_r <= fsum[FRACTION_BITS +: 3];
          end
          if (bg_inc >= track_r || bg_inc[POS_BITS]) begin
            bg_r <= '0;
          end else begin
            bg_r <= bg_inc[POS_BITS-1:0];
          end
          state_r <= S_ADV;
        end
        S_ADV: begin
          // one whole-frame step per cycle, wrapping inside the loop
          if (adv_cnt_r != '0) begin
            adv_cnt_r <= adv_cnt_r - 3'd1;
            if (reverse_r) begin
              read_index_r <= (read_index_r == '0)
                            ? INDEX_BITS'(loop_length_r - FRAMES_BITS'(1))
                            : read_index_r - INDEX_BITS'(1);
            end else begin
              read_index_r <= (FRAMES_BITS'(read_index_r) + FRAMES_BITS'(1) >= loop_length_r)
                            ? '0 : read_index_r + INDEX_BITS'(1);
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_cnt_r != '0) begin
            div_cnt_r <= div_cnt_r - CNT_BITS'(1);
            div_q_r   <= {div_q_r[DIV_BITS-2:0], div_bit};
            div_rem_r <= div_bit ? FRAMES_BITS'(div_trial - (FRAMES_BITS+1)'(loop_length_r))
                                 : div_trial[FRAMES_BITS-1:0];
          end else begin
            priority if (div_q_r < DIV_BITS'(QUARTER)) begin
              pitch_r <= QUARTER;
            end else if (div_q_r > DIV_BITS'(FOUR_STEP)) begin
              pitch_r <= FOUR_STEP;
            end else begin
              pitch_r <= div_q_r[STEP_BITS-1:0];
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_left_r    <= res_left_r;
            out_right_r   <= res_right_r;
            out_resume_r  <= res_resume_r;
            out_status_r  <= res_status_r;
            out_looping_r <= active_r;
            out_index_r   <= read_index_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // pitch step always stays in its clamp range
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r >= QUARTER) && (pitch_r <= FOUR_STEP))
    else $error("pitch step out of range");

  // while looping the read index stays inside the loop
  a_index_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (FRAMES_BITS'(read_index_r) < loop_length_r))
    else $error("read index beyond loop length");

  // a rejected command carries no samples and no resume position
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |->
      (out_left_r == '0) && (out_right_r == '0) && (out_resume_r == '0))
    else $error("rejected beat carries data");

  // divider only runs while a loop is active
  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> active_r)
    else $error("divider running without an active loop");

endmodule
